### design/b32dec_pkg.sv
// shared types, codes and constants of the base32 stream decoder
// no dependencies; imported by every module of the decoder
package b32dec_pkg;

    // byte counter width inside the block; the reported count has the same width
    localparam int COUNT_WIDTH = 16;
    localparam int BYTE_COUNT_W = 16;

    // alphabet register codes
    localparam logic [1:0] ALPHA_RFC   = 2'd0;
    localparam logic [1:0] ALPHA_HEX   = 2'd1;
    localparam logic [1:0] ALPHA_CROCK = 2'd2;

    // character class codes
    localparam logic [1:0] CLS_SYMBOL  = 2'd0;
    localparam logic [1:0] CLS_SPACE   = 2'd1;
    localparam logic [1:0] CLS_IGNORED = 2'd2;
    localparam logic [1:0] CLS_INVALID = 2'd3;

    // characters with a role of their own
    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    // one input transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_message;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic [7:0]              data_byte;
        logic                    byte_valid;
        logic [1:0]              char_class;
        logic                    error_seen;
        logic                    message_done;
        logic [BYTE_COUNT_W-1:0] byte_count;
    } t_out_item;

    // lookup answer for one character
    typedef struct packed {
        logic       hit;
        logic [4:0] value;
    } t_sym;

endpackage

### design/b32dec_sym_map.sv
// character to 5-bit symbol lookup for the three alphabets
// depends on b32dec_pkg
module b32dec_sym_map (
    input  logic [7:0]       i_char,
    input  logic [1:0]       i_alphabet,
    output b32dec_pkg::t_sym o_sym
);
    import b32dec_pkg::*;

    logic [7:0] folded;

    // crockford folds lower case to upper case
    always_comb begin
        if (i_char >= "a" && i_char <= "z") begin
            folded = i_char - 8'd32;
        end else begin
            folded = i_char;
        end
    end

    // per-alphabet range decode
    always_comb begin
        o_sym.hit   = 1'b0;
        o_sym.value = 5'd0;
        unique case (i_alphabet)
            ALPHA_HEX: begin
                if (i_char >= "0" && i_char <= "9") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(i_char - "0");
                end else if (i_char >= "A" && i_char <= "V") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(i_char - "A" + 8'd10);
                end
            end
            ALPHA_CROCK: begin
                if (folded >= "0" && folded <= "9") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(folded - "0");
                end else if (folded == "O") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'd0;
                end else if (folded == "I" || folded == "L") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'd1;
                end else if (folded >= "A" && folded <= "H") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(folded - "A" + 8'd10);
                end else if (folded == "J" || folded == "K") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(folded - "J" + 8'd18);
                end else if (folded == "M" || folded == "N") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(folded - "M" + 8'd20);
                end else if (folded >= "P" && folded <= "T") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(folded - "P" + 8'd22);
                end else if (folded >= "V" && folded <= "Z") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(folded - "V" + 8'd27);
                end
            end
            default: begin
                // rfc 4648, also for the unused code
                if (i_char >= "A" && i_char <= "Z") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(i_char - "A");
                end else if (i_char >= "2" && i_char <= "7") begin
                    o_sym.hit   = 1'b1;
                    o_sym.value = 5'(i_char - "2" + 8'd26);
                end
            end
        endcase
    end

endmodule

### design/b32dec_step.sv
// message state of the decoder and the single-pass decode of one character
// depends on b32dec_pkg and b32dec_sym_map
module b32dec_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [1:0]            i_alphabet,
    input  b32dec_pkg::t_in_item  i_item,
    output b32dec_pkg::t_out_item o_result
);
    import b32dec_pkg::*;

    logic [6:0]             r_bits;
    logic [2:0]             r_count;
    logic                   r_pad;
    logic                   r_err;
    logic [COUNT_WIDTH-1:0] r_bytes;

    logic [6:0]             n_bits;
    logic [2:0]             n_count;
    logic                   n_pad;
    logic                   n_err;
    logic [COUNT_WIDTH-1:0] n_bytes;

    t_sym        sym;
    logic [11:0] acc;
    logic [3:0]  fill;
    logic [3:0]  rest;
    logic [11:0] shifted;
    logic [2:0]  keep;
    logic [7:0]  data;
    logic        full;
    logic [1:0]  cls;
    logic        is_space;

    b32dec_sym_map u_sym_map (
        .i_char     (i_item.char_code),
        .i_alphabet (i_alphabet),
        .o_sym      (sym)
    );

    // shift five bits into the residual buffer
    always_comb begin
        acc     = {r_bits, sym.value};
        fill    = {1'b0, r_count} + 4'd5;
        full    = fill >= 4'd8;
        rest    = full ? fill - 4'd8 : fill;
        keep    = rest[2:0];
        shifted = acc >> rest;
        data    = shifted[7:0];
    end

    assign is_space = (i_item.char_code == CHAR_CR) || (i_item.char_code == CHAR_LF)
                   || (i_item.char_code == CHAR_TAB) || (i_item.char_code == CHAR_SP);

    // classify the character and form the next message state
    always_comb begin
        n_bits  = r_bits;
        n_count = r_count;
        n_pad   = r_pad;
        n_err   = r_err;
        n_bytes = r_bytes;
        o_result.data_byte  = 8'd0;
        o_result.byte_valid = 1'b0;
        priority if (r_pad || r_err) begin
            cls = CLS_IGNORED;
        end else if (is_space) begin
            cls = CLS_SPACE;
        end else if (i_item.char_code == CHAR_PAD) begin
            cls   = CLS_IGNORED;
            n_pad = 1'b1;
        end else if (!sym.hit) begin
            cls   = CLS_INVALID;
            n_err = 1'b1;
        end else begin
            cls     = CLS_SYMBOL;
            n_count = keep;
            n_bits  = acc[6:0] & 7'((8'd1 << keep) - 8'd1);
            if (full) begin
                o_result.data_byte  = data;
                o_result.byte_valid = 1'b1;
                if (r_bytes != {COUNT_WIDTH{1'b1}}) begin
                    n_bytes = r_bytes + 1'b1;
                end
            end
        end
        o_result.char_class   = cls;
        o_result.error_seen   = n_err;
        o_result.message_done = i_item.end_of_message;
        o_result.byte_count   = BYTE_COUNT_W'(n_bytes);
    end

    // state moves on when the transaction passes to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_count <= '0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
            r_bytes <= '0;
        end else if (i_advance) begin
            if (i_item.end_of_message) begin
                r_bits  <= '0;
                r_count <= '0;
                r_pad   <= 1'b0;
                r_err   <= 1'b0;
                r_bytes <= '0;
            end else begin
                r_bits  <= n_bits;
                r_count <= n_count;
                r_pad   <= n_pad;
                r_err   <= n_err;
                r_bytes <= n_bytes;
            end
        end
    end

endmodule

### design/base32_stream_decoder_unit.sv
// top level of the base32 stream decoder: handshake, input and result registers
// depends on b32dec_pkg and b32dec_step
//
// Streaming Base32 decoder. Each input transaction carries one text character
// and gives exactly one result transaction: the decoded byte when the
// character completed one, the character class, the sticky error flag and
// the running byte count; end_of_message closes the message and clears its
// state. The alphabet register (RFC 4648, base32hex, Crockford) is written
// through the configuration channel, always ready; the user must write it
// only while the decoder is idle, the block itself does not enforce this.
// Throughput is one character per clock while the output is not stalled:
// the symbol lookup and the residual shift sit in one stage between the
// input register and the result register. The input side stalls only while
// both registers are full and the output is stalled.
module base32_stream_decoder_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  b32dec_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output b32dec_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_data
);
    import b32dec_pkg::*;

    logic [1:0] r_alpha;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item result;
    logic      advance;
    logic      accept;

    // configuration register write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RFC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_alpha <= i_cfg_data;
        end
    end

    // result register frees up when empty or taken this cycle
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_data;
        end
    end

    b32dec_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_alphabet (r_alpha),
        .i_item     (r_in_item),
        .o_result   (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule
